FILE: hw/rtl/qmn_pkg.sv
// shared types and constants for the normalized quaternion product pipeline
package qmn_pkg;

	// component width, Q1.(CW-1)
	localparam int CW = 16;
	// normalized magnitude width and its halves
	localparam int MW = 64;
	localparam int HW = MW / 2;
	// exact product component width, signed
	localparam int PW = 2 * CW + 2;
	// sum of squares width
	localparam int SW = 2 * MW;
	// square root partial remainder width
	localparam int RW = MW + 3;
	// divide numerator width
	localparam int NW = MW + CW;
	// leading zero normalizer steps
	localparam int SHIFT_STAGES = $clog2(MW);

	// stage counts of each unit and the total start-to-done latency
	localparam int PROD_LAT = 4;
	localparam int NORM_LAT = 3 + SHIFT_STAGES + 4;
	localparam int SQRT_LAT = MW;
	localparam int DIV_LAT = CW + 1;
	localparam int LATENCY = PROD_LAT + NORM_LAT + SQRT_LAT + DIV_LAT + 1;

	typedef logic signed [CW-1:0] comp_t;
	typedef logic signed [2*CW-1:0] prod_t;
	typedef logic [MW-1:0] mag_t;
	typedef mag_t [3:0] mag4_t;
	typedef logic [SW-1:0] wide_t;
	typedef logic [3:0][CW-1:0] quo4_t;

	// one operand transfer
	typedef struct packed {
		comp_t a_w;
		comp_t a_x;
		comp_t a_y;
		comp_t a_z;
		comp_t b_w;
		comp_t b_x;
		comp_t b_y;
		comp_t b_z;
	} qmn_in_t;

	// one result transfer
	typedef struct packed {
		comp_t r_w;
		comp_t r_x;
		comp_t r_y;
		comp_t r_z;
		logic  zero_norm;
	} qmn_out_t;

	// per-item flags carried down the pipe
	typedef struct packed {
		logic [3:0] neg;
		logic       zero;
	} side_t;

endpackage

FILE: hw/rtl/qmn_product.sv
// hamilton product stages: multiply, accumulate, sign and magnitude
module qmn_product (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  qmn_pkg::qmn_in_t in_item,
	output logic             out_valid,
	output qmn_pkg::side_t   out_side,
	output qmn_pkg::mag4_t   out_mag
);
	import qmn_pkg::*;

	// term t of component c subtracts when bit 4*c+t is set
	localparam logic [15:0] SUB_MASK = 16'h428E;

	logic                v_s1, v_s2, v_s3, v_s4;
	qmn_in_t             item_s1;
	comp_t               a_v [4];
	comp_t               b_v [4];
	prod_t               prod_c [16];
	prod_t               prod_s2 [16];
	logic signed [PW-1:0] sum_c [4];
	logic signed [PW-1:0] sum_s3 [4];
	logic [3:0]          neg_s4;
	mag4_t               mag_s4;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// operand register
	always_ff @(posedge clk) begin
		item_s1 <= in_item;
	end

	assign a_v[0] = item_s1.a_w;
	assign a_v[1] = item_s1.a_x;
	assign a_v[2] = item_s1.a_y;
	assign a_v[3] = item_s1.a_z;
	assign b_v[0] = item_s1.b_w;
	assign b_v[1] = item_s1.b_x;
	assign b_v[2] = item_s1.b_y;
	assign b_v[3] = item_s1.b_z;

	// sixteen products, component c term t pairs a[t] with b[t xor c]
	for (genvar c = 0; c < 4; c++) begin : g_comp
		for (genvar t = 0; t < 4; t++) begin : g_term
			localparam int BI = t ^ c;
			assign prod_c[4*c+t] = $signed(a_v[t]) * $signed(b_v[BI]);
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_c;
	end

	// signed accumulation of four terms per component
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			sum_c[c] = '0;
			for (int t = 0; t < 4; t++) begin
				if (SUB_MASK[4*c+t]) begin
					sum_c[c] = sum_c[c] - {{(PW-2*CW){prod_s2[4*c+t][2*CW-1]}},
						prod_s2[4*c+t]};
				end else begin
					sum_c[c] = sum_c[c] + {{(PW-2*CW){prod_s2[4*c+t][2*CW-1]}},
						prod_s2[4*c+t]};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		sum_s3 <= sum_c;
	end

	// split into sign and magnitude
	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			neg_s4[c] <= sum_s3[c][PW-1];
			if (sum_s3[c][PW-1]) begin
				mag_s4[c] <= {{(MW-PW){1'b0}}, PW'('0 - sum_s3[c])};
			end else begin
				mag_s4[c] <= {{(MW-PW){1'b0}}, PW'(sum_s3[c])};
			end
		end
	end

	assign out_valid = v_s4;
	assign out_side  = '{neg: neg_s4, zero: 1'b0};
	assign out_mag   = mag_s4;

endmodule

FILE: hw/rtl/qmn_norm.sv
// largest magnitude, common normalizing shift and sum of squares
module qmn_norm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  qmn_pkg::side_t in_side,
	input  qmn_pkg::mag4_t in_mag,
	output logic           out_valid,
	output qmn_pkg::side_t out_side,
	output qmn_pkg::mag4_t out_mag,
	output qmn_pkg::wide_t out_sum
);
	import qmn_pkg::*;

	logic  v_s1, v_s2, v_s3;
	side_t side_s1, side_s2;
	mag4_t mag_s1, mag_s2;
	mag_t  m01_s1, m23_s1, big_c, big_s2;

	logic  shf_v_s    [0:SHIFT_STAGES];
	side_t shf_side_s [0:SHIFT_STAGES];
	mag4_t shf_mag_s  [0:SHIFT_STAGES];
	mag_t  shf_big_s  [0:SHIFT_STAGES];

	logic  sq_v_s1, sq_v_s2, sq_v_s3, sq_v_s4;
	side_t sq_side_s1, sq_side_s2, sq_side_s3, sq_side_s4;
	mag4_t sq_mag_s1, sq_mag_s2, sq_mag_s3, sq_mag_s4;
	mag_t  ll_s1 [4];
	mag_t  lh_s1 [4];
	mag_t  hh_s1 [4];
	wide_t sq_s2 [4];
	wide_t s01_s3, s23_s3, sum_s4;

	// valid chain outside the shifter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			sq_v_s1 <= 1'b0;
			sq_v_s2 <= 1'b0;
			sq_v_s3 <= 1'b0;
			sq_v_s4 <= 1'b0;
		end else begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			sq_v_s1 <= shf_v_s[SHIFT_STAGES];
			sq_v_s2 <= sq_v_s1;
			sq_v_s3 <= sq_v_s2;
			sq_v_s4 <= sq_v_s3;
		end
	end

	assign shf_v_s[0] = v_s3;

	// pairwise maximum
	always_ff @(posedge clk) begin
		mag_s1  <= in_mag;
		side_s1 <= in_side;
		m01_s1  <= (in_mag[0] > in_mag[1]) ? in_mag[0] : in_mag[1];
		m23_s1  <= (in_mag[2] > in_mag[3]) ? in_mag[2] : in_mag[3];
	end

	// overall maximum and zero detect
	assign big_c = (m01_s1 > m23_s1) ? m01_s1 : m23_s1;

	always_ff @(posedge clk) begin
		mag_s2  <= mag_s1;
		big_s2  <= big_c;
		side_s2 <= '{neg: side_s1.neg, zero: (big_c == '0)};
	end

	// top bit set: truncate everything by one bit
	always_ff @(posedge clk) begin
		shf_side_s[0] <= side_s2;
		for (int c = 0; c < 4; c++) begin
			shf_mag_s[0][c] <= big_s2[MW-1] ? (mag_s2[c] >> 1) : mag_s2[c];
		end
		shf_big_s[0] <= big_s2[MW-1] ? (big_s2 >> 1) : big_s2;
	end

	// binary search left shift until the maximum has its top bit one below msb
	for (genvar j = 0; j < SHIFT_STAGES; j++) begin : g_shift
		localparam int K = HW >> j;
		logic hit;

		assign hit = (shf_big_s[j][MW-2 -: K] == '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				shf_v_s[j+1] <= 1'b0;
			end else begin
				shf_v_s[j+1] <= shf_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			shf_side_s[j+1] <= shf_side_s[j];
			for (int c = 0; c < 4; c++) begin
				shf_mag_s[j+1][c] <= hit ? (shf_mag_s[j][c] << K) : shf_mag_s[j][c];
			end
			shf_big_s[j+1] <= hit ? (shf_big_s[j] << K) : shf_big_s[j];
		end
	end

	// squares from half-width partial products
	always_ff @(posedge clk) begin
		sq_side_s1 <= shf_side_s[SHIFT_STAGES];
		sq_mag_s1  <= shf_mag_s[SHIFT_STAGES];
		for (int c = 0; c < 4; c++) begin
			ll_s1[c] <= shf_mag_s[SHIFT_STAGES][c][HW-1:0] *
				shf_mag_s[SHIFT_STAGES][c][HW-1:0];
			lh_s1[c] <= shf_mag_s[SHIFT_STAGES][c][HW-1:0] *
				shf_mag_s[SHIFT_STAGES][c][MW-1:HW];
			hh_s1[c] <= shf_mag_s[SHIFT_STAGES][c][MW-1:HW] *
				shf_mag_s[SHIFT_STAGES][c][MW-1:HW];
		end
	end

	always_ff @(posedge clk) begin
		sq_side_s2 <= sq_side_s1;
		sq_mag_s2  <= sq_mag_s1;
		for (int c = 0; c < 4; c++) begin
			sq_s2[c] <= {hh_s1[c], {MW{1'b0}}} + (SW'(lh_s1[c]) << (HW + 1)) +
				SW'(ll_s1[c]);
		end
	end

	// sum of the four squares
	always_ff @(posedge clk) begin
		sq_side_s3 <= sq_side_s2;
		sq_mag_s3  <= sq_mag_s2;
		s01_s3     <= sq_s2[0] + sq_s2[1];
		s23_s3     <= sq_s2[2] + sq_s2[3];
	end

	always_ff @(posedge clk) begin
		sq_side_s4 <= sq_side_s3;
		sq_mag_s4  <= sq_mag_s3;
		sum_s4     <= s01_s3 + s23_s3;
	end

	assign out_valid = sq_v_s4;
	assign out_side  = sq_side_s4;
	assign out_mag   = sq_mag_s4;
	assign out_sum   = sum_s4;

endmodule

FILE: hw/rtl/qmn_isqrt.sv
// pipelined integer square root, one result bit per stage
module qmn_isqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  qmn_pkg::side_t in_side,
	input  qmn_pkg::mag4_t in_mag,
	input  qmn_pkg::wide_t in_sum,
	output logic           out_valid,
	output qmn_pkg::side_t out_side,
	output qmn_pkg::mag4_t out_mag,
	output qmn_pkg::mag_t  out_root
);
	import qmn_pkg::*;

	logic            rt_v_s    [1:MW];
	side_t           rt_side_s [1:MW];
	mag4_t           rt_mag_s  [1:MW];
	logic [RW-1:0]   rt_rem_s  [1:MW];
	mag_t            rt_root_s [1:MW];
	wide_t           rt_rad_s  [1:MW];

	for (genvar j = 1; j <= MW; j++) begin : g_stage
		logic          p_v;
		side_t         p_side;
		mag4_t         p_mag;
		logic [RW-1:0] p_rem;
		mag_t          p_root;
		wide_t         p_rad;
		logic [RW-1:0] r2;
		logic [RW-1:0] trial;

		// previous stage, or the unit input for the first one
		if (j == 1) begin : g_first
			assign p_v    = in_valid;
			assign p_side = in_side;
			assign p_mag  = in_mag;
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_rad  = in_sum;
		end else begin : g_next
			assign p_v    = rt_v_s[j-1];
			assign p_side = rt_side_s[j-1];
			assign p_mag  = rt_mag_s[j-1];
			assign p_rem  = rt_rem_s[j-1];
			assign p_root = rt_root_s[j-1];
			assign p_rad  = rt_rad_s[j-1];
		end

		// bring down two radicand bits and try the next root bit
		assign r2    = {p_rem[RW-3:0], p_rad[SW-1 -: 2]};
		assign trial = {1'b0, p_root, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[j] <= 1'b0;
			end else begin
				rt_v_s[j] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			rt_side_s[j] <= p_side;
			rt_mag_s[j]  <= p_mag;
			rt_rad_s[j]  <= {p_rad[SW-3:0], 2'b00};
			if (r2 >= trial) begin
				rt_rem_s[j]  <= r2 - trial;
				rt_root_s[j] <= {p_root[MW-2:0], 1'b1};
			end else begin
				rt_rem_s[j]  <= r2;
				rt_root_s[j] <= {p_root[MW-2:0], 1'b0};
			end
		end
	end

	assign out_valid = rt_v_s[MW];
	assign out_side  = rt_side_s[MW];
	assign out_mag   = rt_mag_s[MW];
	assign out_root  = rt_root_s[MW];

endmodule

FILE: hw/rtl/qmn_div.sv
// four-lane pipelined restoring divide with round half up
module qmn_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  qmn_pkg::side_t in_side,
	input  qmn_pkg::mag4_t in_mag,
	input  qmn_pkg::mag_t  in_root,
	output logic           out_valid,
	output qmn_pkg::side_t out_side,
	output qmn_pkg::quo4_t out_quo
);
	import qmn_pkg::*;

	logic            dv_v_s    [0:CW];
	side_t           dv_side_s [0:CW];
	mag_t            dv_den_s  [0:CW];
	mag_t            dv_rem_s  [0:CW][4];
	logic [CW-1:0]   dv_low_s  [0:CW][4];
	logic [CW-1:0]   dv_quo_s  [0:CW][4];
	logic [NW-1:0]   num_c     [4];

	// numerator is magnitude times one half lsb scale plus half the divisor
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			num_c[c] = NW'({in_mag[c], {(CW-1){1'b0}}}) + NW'(in_root >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else begin
			dv_v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		dv_side_s[0] <= in_side;
		dv_den_s[0]  <= in_root;
		for (int c = 0; c < 4; c++) begin
			dv_rem_s[0][c] <= num_c[c][NW-1:CW];
			dv_low_s[0][c] <= num_c[c][CW-1:0];
			dv_quo_s[0][c] <= '0;
		end
	end

	// one quotient bit per stage in each lane
	for (genvar j = 1; j <= CW; j++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else begin
				dv_v_s[j] <= dv_v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			dv_side_s[j] <= dv_side_s[j-1];
			dv_den_s[j]  <= dv_den_s[j-1];
		end

		for (genvar c = 0; c < 4; c++) begin : g_lane
			logic [MW:0] r2;
			logic        ge;

			assign r2 = {dv_rem_s[j-1][c], dv_low_s[j-1][c][CW-1]};
			assign ge = (r2 >= {1'b0, dv_den_s[j-1]});

			always_ff @(posedge clk) begin
				dv_rem_s[j][c] <= ge ? MW'(r2 - {1'b0, dv_den_s[j-1]}) : r2[MW-1:0];
				dv_low_s[j][c] <= {dv_low_s[j-1][c][CW-2:0], 1'b0};
				dv_quo_s[j][c] <= {dv_quo_s[j-1][c][CW-2:0], ge};
			end
		end
	end

	assign out_valid = dv_v_s[CW];
	assign out_side  = dv_side_s[CW];
	for (genvar c = 0; c < 4; c++) begin : g_out
		assign out_quo[c] = dv_quo_s[CW][c];
	end

endmodule

FILE: hw/rtl/quaternion_multiply_normalize_core.sv
// top level of the normalized quaternion product pipeline
// Normalized Hamilton product r = (a*b)/|a*b| on Q1.15 components, fully
// pipelined: one operand transfer may start in every cycle and busy is always
// low. Each result appears on res for exactly one cycle with done high;
// results leave in start order and the receiver cannot hold them off. The
// latency is set mostly by the 64-stage bit-serial square root and the
// 16-stage divider (one quotient bit per stage); the rest is the product,
// maximum search, six-step normalizing shifter and the sum of squares. A
// zero product gives zero components with zero_norm set; a component of
// +1.0 saturates to the largest positive code.
module quaternion_multiply_normalize_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  qmn_pkg::qmn_in_t  op,
	output logic              done,
	output qmn_pkg::qmn_out_t res
);
	import qmn_pkg::*;

	localparam logic [CW-1:0] HALF = {1'b1, {(CW-1){1'b0}}};

	logic          in_fire;
	logic          pr_valid, nm_valid, rt_valid, dv_valid;
	side_t         pr_side, nm_side, rt_side, dv_side;
	mag4_t         pr_mag, nm_mag, rt_mag;
	wide_t         nm_sum;
	mag_t          rt_root;
	quo4_t         dv_quo;
	logic [CW-1:0] val_c [4];
	logic          done_q;
	qmn_out_t      res_q;

	// never stalls
	assign busy    = 1'b0;
	assign in_fire = start && !busy;

	qmn_product u_product (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_fire),
		.in_item   (op),
		.out_valid (pr_valid),
		.out_side  (pr_side),
		.out_mag   (pr_mag)
	);

	qmn_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pr_valid),
		.in_side   (pr_side),
		.in_mag    (pr_mag),
		.out_valid (nm_valid),
		.out_side  (nm_side),
		.out_mag   (nm_mag),
		.out_sum   (nm_sum)
	);

	qmn_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (nm_valid),
		.in_side   (nm_side),
		.in_mag    (nm_mag),
		.in_sum    (nm_sum),
		.out_valid (rt_valid),
		.out_side  (rt_side),
		.out_mag   (rt_mag),
		.out_root  (rt_root)
	);

	qmn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rt_valid),
		.in_side   (rt_side),
		.in_mag    (rt_mag),
		.in_root   (rt_root),
		.out_valid (dv_valid),
		.out_side  (dv_side),
		.out_quo   (dv_quo)
	);

	// saturate, apply sign, force zero on a zero product
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			if (dv_side.zero) begin
				val_c[c] = '0;
			end else if (dv_side.neg[c]) begin
				val_c[c] = '0 - dv_quo[c];
			end else if (dv_quo[c] == HALF) begin
				val_c[c] = HALF - 1'b1;
			end else begin
				val_c[c] = dv_quo[c];
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		res_q.r_w       <= $signed(val_c[0]);
		res_q.r_x       <= $signed(val_c[1]);
		res_q.r_y       <= $signed(val_c[2]);
		res_q.r_z       <= $signed(val_c[3]);
		res_q.zero_norm <= dv_side.zero;
	end

	assign done = done_q;
	assign res  = res_q;

`ifndef ASSERT_OFF
	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> ##LATENCY done)
		else $error("result missing after start");

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |-> ##LATENCY !done)
		else $error("result without a matching start");

	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.zero_norm) |->
		(res.r_w == '0 && res.r_x == '0 && res.r_y == '0 && res.r_z == '0))
		else $error("zero norm result has nonzero components");

	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !res.zero_norm) |->
		(res.r_w != '0 || res.r_x != '0 || res.r_y != '0 || res.r_z != '0))
		else $error("normalized result is all zero");
`endif

endmodule

FILE: verif/quaternion_multiply_normalize_core_tb.sv
// testbench for the normalized quaternion product core: directed and random operands
module quaternion_multiply_normalize_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qmn_pkg::*;

	localparam int STALL_LIMIT = 4 * LATENCY + 200;
	localparam comp_t ONE_HALF = comp_t'(16384);
	localparam comp_t MAX_POS  = comp_t'(32767);
	localparam comp_t MAX_NEG  = comp_t'(-32768);

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	qmn_in_t  op;
	logic     done;
	qmn_out_t res;

	qmn_out_t unit_q[$];
	int       error_count;
	int       stall_cycles;
	bit       idle_on;

	quaternion_multiply_normalize_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.op     (op),
		.done   (done),
		.res    (res)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// exact hamilton product, scaled to unit norm and saturated
	function automatic qmn_out_t unit_product(qmn_in_t q);
		longint    aw, ax, ay, az, bw, bx, by, bz;
		longint    p [4];
		logic [63:0]  m [4];
		logic         neg [4];
		logic [63:0]  big, n, qv, lim;
		logic [127:0] s, t, num;
		logic [15:0]  r [4];
		qmn_out_t     o;
		int           sh;
		aw = longint'(q.a_w); ax = longint'(q.a_x); ay = longint'(q.a_y); az = longint'(q.a_z);
		bw = longint'(q.b_w); bx = longint'(q.b_x); by = longint'(q.b_y); bz = longint'(q.b_z);
		p[0] = aw*bw - ax*bx - ay*by - az*bz;
		p[1] = aw*bx + ax*bw + ay*bz - az*by;
		p[2] = aw*by - ax*bz + ay*bw + az*bx;
		p[3] = aw*bz + ax*by - ay*bx + az*bw;
		big = '0;
		for (int i = 0; i < 4; i++) begin
			neg[i] = p[i] < 0;
			m[i] = neg[i] ? 64'(-p[i]) : 64'(p[i]);
			if (m[i] > big) big = m[i];
		end
		o = '0;
		if (big == '0) begin
			o.zero_norm = 1'b1;
			return o;
		end
		// common shift to put the leading one of the largest at bit 62
		sh = 0;
		while (!big[62]) begin
			big = big << 1;
			sh++;
		end
		s = '0;
		for (int i = 0; i < 4; i++) begin
			m[i] = m[i] << sh;
			s = s + {64'd0, m[i]} * {64'd0, m[i]};
		end
		// floor square root, one bit at a time
		n = '0;
		for (int b = 63; b >= 0; b--) begin
			t = {64'd0, n | (64'd1 << b)};
			if (t * t <= s) n = t[63:0];
		end
		// rounded divide and saturate
		for (int i = 0; i < 4; i++) begin
			num = ({64'd0, m[i]} << (CW - 1)) + {64'd0, n >> 1};
			t = num / {64'd0, n};
			qv = t[63:0];
			lim = neg[i] ? 64'd32768 : 64'd32767;
			if (qv > lim) qv = lim;
			r[i] = neg[i] ? 16'(-qv) : qv[15:0];
		end
		o.r_w = comp_t'(r[0]);
		o.r_x = comp_t'(r[1]);
		o.r_y = comp_t'(r[2]);
		o.r_z = comp_t'(r[3]);
		return o;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// drive one operand transfer, optionally after a random idle burst
	task automatic send_operands(qmn_in_t item);
		bit taken;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		start <= 1'b1;
		op    <= item;
		do begin
			@(posedge clk);
			taken = !busy;
		end while (!taken);
	endtask

	task automatic send_pair(comp_t aw, comp_t ax, comp_t ay, comp_t az,
	                         comp_t bw, comp_t bx, comp_t by, comp_t bz);
		qmn_in_t item;
		item = '{aw, ax, ay, az, bw, bx, by, bz};
		send_operands(item);
	endtask

	function automatic comp_t rand_comp();
		case ($urandom_range(0, 5))
			0: return MAX_NEG;
			1: return MAX_POS;
			2: return comp_t'($urandom_range(0, 15)) - comp_t'(8);
			3: return comp_t'($urandom_range(0, 2047)) - comp_t'(1024);
			default: return comp_t'($urandom);
		endcase
	endfunction

	// extremes of every component
	task automatic test_extremes();
		send_pair(MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS);
		send_pair(MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
		send_pair(MAX_NEG, MAX_POS, MAX_NEG, MAX_POS, MAX_POS, MAX_NEG, MAX_POS, MAX_NEG);
		send_pair(MAX_NEG, 0, 0, 0, MAX_NEG, 0, 0, 0);
		send_pair(0, MAX_NEG, 0, 0, 0, 0, MAX_NEG, 0);
		send_pair(0, 0, 0, 1, 0, 0, 1, 0);
		send_pair(1, 0, 0, 0, -1, 0, 0, 0);
		send_pair(-1, -1, -1, -1, 1, 1, 1, 1);
	endtask

	// zero product raises the flag
	task automatic test_zero_product();
		send_pair(0, 0, 0, 0, 0, 0, 0, 0);
		send_pair(0, 0, 0, 0, MAX_POS, MAX_NEG, 5, -7);
		send_pair(MAX_NEG, 3, -1, MAX_POS, 0, 0, 0, 0);
	endtask

	// a component of exactly +1.0 or -1.0 after normalizing
	task automatic test_saturation();
		send_pair(ONE_HALF, 0, 0, 0, ONE_HALF, 0, 0, 0);
		send_pair(ONE_HALF, 0, 0, 0, -ONE_HALF, 0, 0, 0);
		send_pair(0, ONE_HALF, 0, 0, ONE_HALF, 0, 0, 0);
		send_pair(0, ONE_HALF, 0, 0, 0, -ONE_HALF, 0, 0);
		send_pair(0, 0, ONE_HALF, 0, 0, 0, 0, ONE_HALF);
		send_pair(0, 0, 0, ONE_HALF, 0, 0, ONE_HALF, 0);
		send_pair(0, 0, ONE_HALF, 0, 0, ONE_HALF, 0, 0);
	endtask

	// random operands, with idle bursts while idle_on is set
	task automatic test_random(int count);
		qmn_in_t item;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 19) == 0)
				item = '{rand_comp(), 0, 0, 0, rand_comp(), 0, 0, 0};
			else
				item = '{rand_comp(), rand_comp(), rand_comp(), rand_comp(),
				         rand_comp(), rand_comp(), rand_comp(), rand_comp()};
			send_operands(item);
		end
	endtask

	// back-to-back transfers, no idling
	task automatic test_streaming(int count);
		idle_on = 1'b0;
		test_random(count);
	endtask

	// record the expectation of each accepted transfer
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			unit_q.push_back(unit_product(op));
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		qmn_out_t want;
		if (arst_n && done) begin
			if (unit_q.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				want = unit_q.pop_front();
				if (res.r_w !== want.r_w)
					report_mismatch($sformatf("r_w got %0d want %0d", res.r_w, want.r_w));
				if (res.r_x !== want.r_x)
					report_mismatch($sformatf("r_x got %0d want %0d", res.r_x, want.r_x));
				if (res.r_y !== want.r_y)
					report_mismatch($sformatf("r_y got %0d want %0d", res.r_y, want.r_y));
				if (res.r_z !== want.r_z)
					report_mismatch($sformatf("r_z got %0d want %0d", res.r_z, want.r_z));
				if (res.zero_norm !== want.zero_norm)
					report_mismatch($sformatf("zero_norm got %0b want %0b",
						res.zero_norm, want.zero_norm));
			end
		end
	end

	// watchdog on cycles with no transfer in either direction
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		error_count  = 0;
		stall_cycles = 0;
		idle_on      = 1'b1;
		arst_n = 1'b0;
		start  = 1'b0;
		op     = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_zero_product();
		test_saturation();
		test_random(550);
		test_streaming(150);
		start <= 1'b0;

		while (unit_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
